// ----- design/hvr_pkg.sv -----
// ----------------------------------------------------------------------------
// hvr_pkg
// Types and codes shared by the hysteresis valve regulator modules.
// ----------------------------------------------------------------------------
package hvr_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_ENABLE  = 2'd2,
    OP_DISABLE = 2'd3
  } hvr_op_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_OPENED  = 3'd1,
    EV_CLOSED  = 3'd2,
    EV_DISARM  = 3'd3,
    EV_RANGE   = 3'd4,
    EV_DWELL   = 3'd5,
    EV_REFUSED = 3'd6,
    EV_ENABLED = 3'd7
  } hvr_event_t;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SETPOINT = 3'd0,
    REG_DEADBAND = 3'd1,
    REG_DWELL    = 3'd2,
    REG_P_MIN    = 3'd3,
    REG_P_MAX    = 3'd4
  } hvr_reg_t;

  typedef struct packed {
    logic signed [15:0] setpoint;
    logic        [14:0] deadband;
    logic        [31:0] dwell_ms;
    logic signed [15:0] pressure_min;
    logic signed [15:0] pressure_max;
  } hvr_cfg_t;

  typedef struct packed {
    hvr_op_t            op;
    logic signed [15:0] pressure;
    logic               armed;
  } hvr_item_t;

  typedef struct packed {
    logic        enabled;
    logic        valve;
    logic [31:0] timer;
  } hvr_state_t;

  typedef struct packed {
    hvr_event_t event_res;
    logic       running;
    logic       valve_changed;
    logic       valve_on;
  } hvr_result_t;

endpackage

// ----- design/hvr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// hvr_cfg_regs
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module hvr_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hvr_pkg::CfgAddrW-1:0]    cfg_addr,
  input  logic [hvr_pkg::CfgDataW-1:0]    cfg_data,
  output hvr_pkg::hvr_cfg_t               cfg
);
  import hvr_pkg::*;

  hvr_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint     <= 16'sd0;
      cfg_r.deadband     <= 15'd0;
      cfg_r.dwell_ms     <= 32'd0;
      cfg_r.pressure_min <= 16'sd0;
      cfg_r.pressure_max <= 16'sd32767;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_SETPOINT: cfg_r.setpoint     <= cfg_data[15:0];
        REG_DEADBAND: cfg_r.deadband     <= cfg_data[14:0];
        REG_DWELL:    cfg_r.dwell_ms     <= cfg_data;
        REG_P_MIN:    cfg_r.pressure_min <= cfg_data[15:0];
        REG_P_MAX:    cfg_r.pressure_max <= cfg_data[15:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

endmodule

// ----- design/hvr_in_reg.sv -----
// ----------------------------------------------------------------------------
// hvr_in_reg
// Input register stage: captures one item per transfer.
// ----------------------------------------------------------------------------
module hvr_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hvr_pkg::hvr_item_t in_item,
  input  logic               advance,
  output logic               item_valid,
  output hvr_pkg::hvr_item_t item
);
  import hvr_pkg::*;

  logic      valid_r;
  hvr_item_t item_r;

  // The held item leaves whenever the next stage advances.
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- design/hvr_decide.sv -----
// ----------------------------------------------------------------------------
// hvr_decide
// Regulator decision logic: next state and result for one item.
// ----------------------------------------------------------------------------
module hvr_decide (
  input  hvr_pkg::hvr_cfg_t    cfg,
  input  hvr_pkg::hvr_state_t  st,
  input  hvr_pkg::hvr_item_t   item,
  output hvr_pkg::hvr_state_t  st_nxt,
  output hvr_pkg::hvr_result_t res
);
  import hvr_pkg::*;

  logic signed [17:0] p2;
  logic signed [17:0] hi2;
  logic signed [17:0] lo2;
  logic               out_of_range;
  logic               dwell_hold;
  hvr_event_t         ev;
  logic               changed;

  // Band edges in doubled units so half the deadband stays exact.
  assign p2  = 18'(item.pressure) <<< 1;
  assign hi2 = (18'(cfg.setpoint) <<< 1) + $signed({3'b000, cfg.deadband});
  assign lo2 = (18'(cfg.setpoint) <<< 1) - $signed({3'b000, cfg.deadband});

  assign out_of_range = (item.pressure < cfg.pressure_min) ||
                        (item.pressure > cfg.pressure_max);
  assign dwell_hold   = st.timer < cfg.dwell_ms;

  always_comb begin
    st_nxt  = st;
    ev      = EV_NONE;
    changed = 1'b0;
    case (item.op)
      OP_TICK: begin
        if (st.timer != '1) begin
          st_nxt.timer = st.timer + 32'd1;
        end
      end
      OP_SAMPLE: begin
        if (st.enabled) begin
          if (!item.armed || out_of_range) begin
            st_nxt.enabled = 1'b0;
            st_nxt.valve   = 1'b0;
            changed        = st.valve;
            ev             = item.armed ? EV_RANGE : EV_DISARM;
          end else if (dwell_hold) begin
            ev = EV_DWELL;
          end else if (p2 > hi2 && !st.valve) begin
            st_nxt.valve = 1'b1;
            st_nxt.timer = 32'd0;
            changed      = 1'b1;
            ev           = EV_OPENED;
          end else if (p2 < lo2 && st.valve) begin
            st_nxt.valve = 1'b0;
            st_nxt.timer = 32'd0;
            changed      = 1'b1;
            ev           = EV_CLOSED;
          end
        end
      end
      OP_ENABLE: begin
        if (st.enabled) begin
          ev = EV_REFUSED;
        end else begin
          st_nxt.enabled = 1'b1;
          ev             = EV_ENABLED;
        end
      end
      OP_DISABLE: begin
        st_nxt.enabled = 1'b0;
        st_nxt.valve   = 1'b0;
        changed        = st.valve;
        ev             = st.valve ? EV_CLOSED : EV_NONE;
      end
      default: begin
      end
    endcase
  end

  assign res.valve_on      = st_nxt.valve;
  assign res.valve_changed = changed;
  assign res.running       = st_nxt.enabled;
  assign res.event_res     = ev;

endmodule

// ----- design/hysteresis_valve_regulator_core.sv -----
// ----------------------------------------------------------------------------
// hysteresis_valve_regulator_core
// On-off pressure regulator with deadband and minimum valve dwell time.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per transfer. in_tuser carries the operation (tick,
//           pressure sample, enable, disable); in_tdata carries the
//           pressure sample and the arm flag.
//   out_* : exactly one result per input item, in order: valve state,
//           valve-changed flag, running flag and an event code.
//   cfg_* : register writes (setpoint, deadband, dwell, sane range). The
//           port is always ready; write only while no item is in flight.
//   The input register captures the item at the transfer edge, the
//   decision logic then loads the result register once it is free, and
//   the result transfers when the receiver is ready. Throughput is one
//   item per cycle while the receiver keeps taking results, set by the
//   single state update per item in the decision stage.
//   Reset clears both stage valids, disables the regulator, closes the
//   valve, saturates the switch timer and loads the register defaults.
//   When the receiver stalls, the result register holds and the input
//   register takes one more item, then in_tready drops.
// ----------------------------------------------------------------------------
module hysteresis_valve_regulator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [15:0] pressure, [16] armed, [23:17] zero
  input  logic [hvr_pkg::InDataW-1:0]   in_tdata,
  // [1:0] op
  input  logic [hvr_pkg::InUserW-1:0]   in_tuser,
  // Result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] valve_on, [1] valve_changed, [2] running, [5:3] event_res, [7:6] zero
  output logic [hvr_pkg::OutDataW-1:0]  out_tdata,
  // Configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hvr_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [hvr_pkg::CfgDataW-1:0]  cfg_data
);
  import hvr_pkg::*;

  hvr_cfg_t    cfg;
  hvr_item_t   in_item;
  hvr_item_t   item;
  logic        item_valid;
  logic        advance;
  hvr_state_t  st_r;
  hvr_state_t  st_nxt;
  hvr_result_t res;
  hvr_result_t res_r;
  logic        out_valid_r;

  // Unpack the input transfer into the item fields.
  assign in_item.op       = hvr_op_t'(in_tuser);
  assign in_item.pressure = in_tdata[15:0];
  assign in_item.armed    = in_tdata[16];

  hvr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The decision stage moves whenever the result register is free or being
  // emptied this cycle.
  assign advance = !out_valid_r || out_tready;

  hvr_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  hvr_decide u_decide (
    .cfg    (cfg),
    .st     (st_r),
    .item   (item),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Commit the regulator state only when an item actually passes through
  // the decision stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.enabled <= 1'b0;
      st_r.valve   <= 1'b0;
      st_r.timer   <= '1;
    end else if (advance && item_valid) begin
      st_r <= st_nxt;
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.event_res, res_r.running,
                       res_r.valve_changed, res_r.valve_on};

endmodule

// ----- design/hvr_checker.sv -----
// ----------------------------------------------------------------------------
// hvr_checker
// Port-level checks on the regulator result stream.
// ----------------------------------------------------------------------------
module hvr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [hvr_pkg::OutDataW-1:0]  out_tdata
);
  import hvr_pkg::*;

  // A stalled result holds its payload.
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The valve is only ever open while the regulator runs.
  a_open_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[2])
    else $error("valve open while regulator stopped");

  // Valve activity only comes with a switching or stopping event.
  a_changed_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |->
      out_tdata[5:3] == EV_OPENED || out_tdata[5:3] == EV_CLOSED ||
      out_tdata[5:3] == EV_DISARM || out_tdata[5:3] == EV_RANGE)
    else $error("valve changed without a matching event");

  // An opening always drives the valve and leaves it open.
  a_opened: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5:3] == EV_OPENED |-> out_tdata[1] && out_tdata[0])
    else $error("open event without valve drive");

  // Fault stops leave the regulator stopped and the valve closed.
  a_fault_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[5:3] == EV_DISARM || out_tdata[5:3] == EV_RANGE)
      |-> !out_tdata[2] && !out_tdata[0])
    else $error("fault did not stop the regulator");

endmodule

bind hysteresis_valve_regulator_core hvr_checker u_hvr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- sim/hvr_regulator_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvr_regulator_checker
// Watches the input, result and register channels of the valve regulator,
// keeps its own copy of the regulator state and settings, predicts one result
// per accepted item and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module hvr_regulator_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [hvr_pkg::InDataW-1:0]   in_tdata,
  input  logic [hvr_pkg::InUserW-1:0]   in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [hvr_pkg::OutDataW-1:0]  out_tdata,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [hvr_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [hvr_pkg::CfgDataW-1:0]  cfg_data,
  output int                            mismatches,
  output int                            outstanding
);
  import hvr_pkg::*;

  hvr_cfg_t    settings;
  hvr_state_t  plant;
  hvr_result_t valve_reports[$];
  int          error_total = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Drop the regulator and close the valve; report whether it was open.
  function automatic logic shut_valve();
    plant.enabled = 1'b0;
    if (plant.valve) begin
      plant.valve = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic hvr_result_t regulate(hvr_item_t item);
    hvr_result_t res;
    logic        changed;
    hvr_event_t  ev;
    int          p2;
    int          hi2;
    int          lo2;
    int          p;
    changed = 1'b0;
    ev      = EV_NONE;
    p       = int'($signed(item.pressure));
    case (item.op)
      OP_TICK: begin
        if (plant.timer != '1) plant.timer = plant.timer + 32'd1;
      end
      OP_SAMPLE: begin
        if (plant.enabled) begin
          if (!item.armed) begin
            changed = shut_valve();
            ev      = EV_DISARM;
          end else if (p < int'($signed(settings.pressure_min)) ||
                       p > int'($signed(settings.pressure_max))) begin
            changed = shut_valve();
            ev      = EV_RANGE;
          end else if (plant.timer < settings.dwell_ms) begin
            ev = EV_DWELL;
          end else begin
            // Doubled units keep half the deadband exact.
            p2  = 2 * p;
            hi2 = 2 * int'($signed(settings.setpoint)) + int'(settings.deadband);
            lo2 = 2 * int'($signed(settings.setpoint)) - int'(settings.deadband);
            if (p2 > hi2 && !plant.valve) begin
              plant.valve = 1'b1;
              plant.timer = '0;
              changed     = 1'b1;
              ev          = EV_OPENED;
            end else if (p2 < lo2 && plant.valve) begin
              plant.valve = 1'b0;
              plant.timer = '0;
              changed     = 1'b1;
              ev          = EV_CLOSED;
            end
          end
        end
      end
      OP_ENABLE: begin
        if (plant.enabled) begin
          ev = EV_REFUSED;
        end else begin
          plant.enabled = 1'b1;
          ev            = EV_ENABLED;
        end
      end
      default: begin
        changed = shut_valve();
        ev      = changed ? EV_CLOSED : EV_NONE;
      end
    endcase
    res.valve_on      = plant.valve;
    res.valve_changed = changed;
    res.running       = plant.enabled;
    res.event_res     = ev;
    return res;
  endfunction

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_total++;
    end
  endtask

  always @(posedge clk) begin : watch
    hvr_item_t   item;
    hvr_result_t want;
    hvr_result_t got;
    if (!rst_n) begin
      settings.setpoint     = '0;
      settings.deadband     = '0;
      settings.dwell_ms     = '0;
      settings.pressure_min = '0;
      settings.pressure_max = 16'sd32767;
      plant.enabled         = 1'b0;
      plant.valve           = 1'b0;
      plant.timer           = '1;
      valve_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_SETPOINT: settings.setpoint     = cfg_data[15:0];
          REG_DEADBAND: settings.deadband     = cfg_data[14:0];
          REG_DWELL:    settings.dwell_ms     = cfg_data;
          REG_P_MIN:    settings.pressure_min = cfg_data[15:0];
          REG_P_MAX:    settings.pressure_max = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = hvr_result_t'(out_tdata[5:0]);
        if (valve_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, out_tdata);
          error_total++;
        end else begin
          want = valve_reports.pop_front();
          compare_field("valve_on", want.valve_on, got.valve_on);
          compare_field("valve_changed", want.valve_changed, got.valve_changed);
          compare_field("running", want.running, got.running);
          compare_field("event_res", want.event_res, got.event_res);
        end
      end
      if (in_tvalid && in_tready) begin
        item.op       = hvr_op_t'(in_tuser);
        item.pressure = in_tdata[15:0];
        item.armed    = in_tdata[16];
        valve_reports.push_back(regulate(item));
      end
    end
    outstanding <= valve_reports.size();
    mismatches  <= error_total;
  end

endmodule

// ----- sim/tb_hysteresis_valve_regulator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hysteresis_valve_regulator_core
// Drives the valve regulator with a directed sequence and then with random
// phases under changing settings, with bursty input and a stalling receiver.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_hysteresis_valve_regulator_core;
  import hvr_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int PhaseCount  = 10;
  localparam int PhaseItems  = 170;
  localparam int DrainCycles = 8;

  // Receiver behaviors, each held for a random stretch of cycles.
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_EVERY3,
    SINK_SPARSE
  } sink_mode_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [InDataW-1:0]    in_tdata   = '0;
  logic [InUserW-1:0]    in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OutDataW-1:0]   out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CfgAddrW-1:0]   cfg_addr   = '0;
  logic [CfgDataW-1:0]   cfg_data   = '0;

  int                    mismatches;
  int                    outstanding;
  int                    cycle_count = 0;

  // Settings last loaded, used only to shape the stimulus.
  int                    cur_setpoint = 0;
  int                    cur_deadband = 0;
  int                    cur_p_min    = 0;
  int                    cur_p_max    = 32767;
  // Best guess whether the regulator is running; steers re-enables.
  logic                  regulator_up = 1'b0;
  int                    burst_left   = 0;

  sink_mode_t            sink_mode    = SINK_OPEN;
  int                    mode_left    = 0;

  always #1 clk = ~clk;

  hysteresis_valve_regulator_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  hvr_regulator_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Receiver: switch between always ready, coin flips, a periodic ready pattern
  // and long stalls, so backpressure lands on every phase of the pipeline.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(32, 256);
    end else begin
      mode_left--;
    end
    case (sink_mode)
      SINK_OPEN:   out_tready <= 1'b1;
      SINK_COIN:   out_tready <= 1'($urandom_range(0, 1));
      SINK_EVERY3: out_tready <= (mode_left % 3 == 0);
      default:     out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog: any run that stalls or loses a result ends here.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Offer one item and hold it until the transfer. Between bursts, drop
  // valid for a random gap first.
  task automatic send_item(hvr_op_t op, int p, logic armed);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, armed, 16'(p)};
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold the input off until every predicted result has been taken.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Keep cfg_valid high across consecutive writes; the caller lowers it.
  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drain, then write all registers with junk in the unused upper bits,
  // plus one write to an index beyond the register map.
  task automatic load_settings(int sp, int db, logic [31:0] dwell, int p_min, int p_max);
    wait_idle();
    write_reg(REG_SETPOINT, {16'($urandom), 16'(sp)});
    write_reg(REG_DEADBAND, {17'($urandom), 15'(db)});
    write_reg(REG_DWELL, dwell);
    write_reg(REG_P_MIN, {16'($urandom), 16'(p_min)});
    write_reg(REG_P_MAX, {16'($urandom), 16'(p_max)});
    write_reg(CfgAddrW'($urandom_range(5, 7)), $urandom);
    cfg_valid    <= 1'b0;
    cur_setpoint = sp;
    cur_deadband = db;
    cur_p_min    = p_min;
    cur_p_max    = p_max;
  endtask

  // Mostly a running regulator fed with ticks and sane samples around the
  // band; the rest is disarms, wild pressures, stray enables and disables.
  task automatic random_item();
    int   pick;
    int   spread;
    int   p;
    int   lo;
    int   hi;
    if (!regulator_up && $urandom_range(0, 3) != 0) begin
      send_item(OP_ENABLE, $urandom, 1'($urandom));
      regulator_up = 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      lo   = (cur_p_min <= cur_p_max) ? cur_p_min : -32768;
      hi   = (cur_p_min <= cur_p_max) ? cur_p_max : 32767;
      if (pick < 30) begin
        send_item(OP_TICK, $urandom, 1'($urandom));
      end else if (pick < 87) begin
        if (pick < 82) begin
          spread = cur_deadband / 2 + 30;
          p = clamp(cur_setpoint + int'($urandom_range(0, 2 * spread)) - spread, lo, hi);
        end else begin
          p = int'($signed(16'($urandom)));
        end
        send_item(OP_SAMPLE, p, 1'b1);
        if (p < cur_p_min || p > cur_p_max) regulator_up = 1'b0;
      end else if (pick < 91) begin
        send_item(OP_SAMPLE, $urandom, 1'b0);
        regulator_up = 1'b0;
      end else if (pick < 95) begin
        send_item(OP_ENABLE, $urandom, 1'($urandom));
        regulator_up = 1'b1;
      end else begin
        send_item(OP_DISABLE, $urandom, 1'($urandom));
        regulator_up = 1'b0;
      end
    end
  endtask

  initial begin : stimulus
    int sp;
    int lo;
    int hi;
    int db;
    logic [31:0] dwell;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: setpoint 0, no deadband, no dwell, range 0..32767.
    send_item(OP_TICK, 0, 1'b0);          // timer already saturated
    send_item(OP_SAMPLE, 100, 1'b1);      // disabled, so ignored
    send_item(OP_DISABLE, 0, 1'b0);       // nothing to close
    send_item(OP_ENABLE, 0, 1'b0);
    send_item(OP_ENABLE, -1, 1'b1);       // already running: refused
    send_item(OP_SAMPLE, 1, 1'b1);        // first switch allowed: open
    send_item(OP_SAMPLE, 32767, 1'b1);    // already open
    send_item(OP_SAMPLE, -1, 1'b1);       // below range: fault closes valve
    send_item(OP_ENABLE, 0, 1'b0);
    send_item(OP_SAMPLE, 0, 1'b1);        // exactly on setpoint
    send_item(OP_SAMPLE, -32768, 1'b0);   // disarm wins over range fault
    send_item(OP_ENABLE, 0, 1'b0);
    send_item(OP_SAMPLE, 5, 1'b1);        // open
    send_item(OP_DISABLE, 0, 1'b0);       // closes the open valve
    send_item(OP_DISABLE, 0, 1'b0);

    // Band 80..120 in doubled units 160..240, three ticks of dwell.
    load_settings(100, 40, 32'd3, -32768, 32767);
    send_item(OP_ENABLE, 0, 1'b0);
    send_item(OP_SAMPLE, 121, 1'b1);      // timer still zero: dwell hold
    repeat (3) send_item(OP_TICK, 0, 1'b0);
    send_item(OP_SAMPLE, 120, 1'b1);      // upper band edge, no switch
    send_item(OP_SAMPLE, 121, 1'b1);      // open
    send_item(OP_SAMPLE, 79, 1'b1);       // dwell hold again
    repeat (3) send_item(OP_TICK, 0, 1'b0);
    send_item(OP_SAMPLE, 80, 1'b1);       // lower band edge, no switch
    send_item(OP_SAMPLE, 79, 1'b1);       // close

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: load_settings(-32768, 0, 32'd0, -32768, 32767);
        1: load_settings(32767, 32767, 32'hFFFF_FFFF, -32768, 32767);
        2: load_settings(0, 100, 32'd0, 32767, -32768);   // swapped range
        default: begin
          sp = int'($urandom_range(0, 4000)) - 2000;
          case ($urandom_range(0, 5))
            0:       db = 0;
            1:       db = 32767;
            default: db = $urandom_range(0, 300);
          endcase
          case ($urandom_range(0, 7))
            0, 1:    dwell = '0;
            2:       dwell = $urandom;
            default: dwell = $urandom_range(1, 10);
          endcase
          lo = clamp(sp - int'($urandom_range(0, 2500)), -32768, 32767);
          hi = clamp(sp + int'($urandom_range(0, 2500)), -32768, 32767);
          if ($urandom_range(0, 7) == 0) load_settings(sp, db, dwell, hi + 1, lo);
          else load_settings(sp, db, dwell, lo, hi);
        end
      endcase
      repeat (PhaseItems) random_item();
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
